// File: src/atip_pkg.sv
// ----------------------------------------------------------------------------
// atip_pkg
// Shared widths, atmosphere tables, field codes and control structs for the
// standard-atmosphere table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package atip_pkg;

  localparam int ROWS       = 21;
  localparam int NUM_POINTS = 21;
  localparam int NPTS       = (NUM_POINTS < 2) ? 2 : ((NUM_POINTS > ROWS) ? ROWS : NUM_POINTS);
  localparam int IDX_W      = $clog2(ROWS);

  localparam int ALT_W  = 19;
  localparam int DENS_W = 28;
  localparam int GRAV_W = 14;
  localparam int TEMP_W = 14;
  localparam int PRES_W = 24;

  localparam int VAL_W  = 29;
  localparam int MAG_W  = 25;
  localparam int OFF_W  = 14;
  localparam int DX_W   = 14;
  localparam int PROD_W = MAG_W + OFF_W;
  localparam int Q_W    = MAG_W;
  localparam int CNT_W  = $clog2(Q_W + 1);

  localparam int FLD_W = 2;
  localparam logic [FLD_W-1:0] FLD_DENS = 2'd0;
  localparam logic [FLD_W-1:0] FLD_GRAV = 2'd1;
  localparam logic [FLD_W-1:0] FLD_TEMP = 2'd2;
  localparam logic [FLD_W-1:0] FLD_PRES = 2'd3;

  localparam int ALT_TAB [ROWS] = '{
    -1000, 0, 1000, 2000, 3000, 4000, 5000, 6000,
    7000, 8000, 9000, 10000, 15000, 20000, 25000, 30000,
    40000, 50000, 60000, 70000, 80000
  };

  localparam int DENS_TAB [ROWS] = '{
    134700000, 122500000, 111200000, 100700000, 90930000, 81940000,
    73640000, 66010000, 59000000, 52580000, 46710000, 41350000,
    19480000, 8891000, 4008000, 1841000, 399600, 102700,
    30970, 8283, 1846
  };

  localparam int GRAV_TAB [ROWS] = '{
    9810, 9807, 9804, 9801, 9797, 9794, 9791, 9788,
    9785, 9782, 9779, 9776, 9761, 9745, 9730, 9715,
    9684, 9654, 9624, 9594, 9564
  };

  localparam int TEMP_TAB [ROWS] = '{
    2150, 1500, 850, 200, -449, -1098, -1747, -2396,
    -3045, -3694, -4342, -4990, -5650, -5650, -5160, -4664,
    -2280, -250, -2613, -5357, -7451
  };

  localparam int PRES_TAB [ROWS] = '{
    11390000, 10132500, 8988000, 7950000, 7012000, 6166000, 5405000,
    4722000, 4111000, 3565000, 3080000, 2650000, 1211000, 552900,
    254900, 119700, 28700, 7978, 2196, 520, 110
  };

  typedef struct packed {
    logic             load;
    logic             seg_inc;
    logic             mul;
    logic             div_start;
    logic             store;
    logic             out_load;
    logic [FLD_W-1:0] field;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic div_done;
    logic out_full;
  } stat_t;

  function automatic logic signed [ALT_W-1:0] alt_at(input logic [IDX_W-1:0] idx);
    alt_at = ALT_W'(ALT_TAB[idx]);
  endfunction

  function automatic logic signed [VAL_W-1:0] val_at(input logic [FLD_W-1:0] fld,
                                                      input logic [IDX_W-1:0] idx);
    case (fld)
      FLD_DENS: val_at = VAL_W'(DENS_TAB[idx]);
      FLD_GRAV: val_at = VAL_W'(GRAV_TAB[idx]);
      FLD_TEMP: val_at = VAL_W'(TEMP_TAB[idx]);
      FLD_PRES: val_at = VAL_W'(PRES_TAB[idx]);
      default:  val_at = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: src/atip_alt_if.sv
// ----------------------------------------------------------------------------
// atip_alt_if
// Altitude channel: valid/ready handshake carrying one altitude per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface atip_alt_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [atip_pkg::ALT_W-1:0]    altitude;

  modport source (output valid, output altitude, input ready);
  modport sink   (input valid, input altitude, output ready);
endinterface

`default_nettype wire

// File: src/atip_atm_if.sv
// ----------------------------------------------------------------------------
// atip_atm_if
// Atmosphere channel: valid/ready handshake carrying one interpolated result
// per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface atip_atm_if;
  logic                                 valid;
  logic                                 ready;
  logic        [atip_pkg::DENS_W-1:0]   density;
  logic        [atip_pkg::GRAV_W-1:0]   gravity;
  logic signed [atip_pkg::TEMP_W-1:0]   temperature;
  logic        [atip_pkg::PRES_W-1:0]   pressure;
  logic                                 below_range;
  logic                                 above_range;

  modport source (output valid, output density, output gravity, output temperature,
                  output pressure, output below_range, output above_range, input ready);
  modport sink   (input valid, input density, input gravity, input temperature,
                  input pressure, input below_range, input above_range, output ready);
endinterface

`default_nettype wire

// File: src/atip_ctrl.sv
// ----------------------------------------------------------------------------
// atip_ctrl
// Sequencer: take an altitude, walk the segments, then run multiply and
// divide once per field and hand the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module atip_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire atip_pkg::stat_t stat,
  output atip_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_START  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]                 state;
  logic [2:0]                 state_next;
  logic [atip_pkg::FLD_W-1:0] field;
  logic [atip_pkg::FLD_W-1:0] field_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      field <= atip_pkg::FLD_DENS;
    end else begin
      state <= state_next;
      field <= field_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    field_next = field;
    cmd        = '0;
    cmd.field  = field;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.search_done) begin
          field_next = atip_pkg::FLD_DENS;
          state_next = S_MUL;
        end else begin
          cmd.seg_inc = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.store = 1'b1;
          if (field == atip_pkg::FLD_PRES) begin
            state_next = S_OUT;
          end else begin
            field_next = field + 2'd1;
            state_next = S_MUL;
          end
        end
      end
      S_OUT: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/atip_div.sv
// ----------------------------------------------------------------------------
// atip_div
// Restoring divider: one quotient bit per cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module atip_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [atip_pkg::PROD_W-1:0] dividend,
  input  wire logic [atip_pkg::DX_W-1:0]   divisor,
  output logic      [atip_pkg::Q_W-1:0]    quotient,
  output logic                             done
);

  logic [atip_pkg::PROD_W-1:0] rem;
  logic [atip_pkg::PROD_W-1:0] sh;
  logic [atip_pkg::CNT_W-1:0]  cnt;
  logic                        busy;
  logic                        fits;

  assign fits = (rem >= sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == atip_pkg::CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == atip_pkg::CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      sh       <= atip_pkg::PROD_W'(divisor) << (atip_pkg::Q_W - 1);
      quotient <= '0;
      cnt      <= atip_pkg::CNT_W'(atip_pkg::Q_W);
    end else if (busy) begin
      if (fits) begin
        rem <= rem - sh;
      end
      quotient <= {quotient[atip_pkg::Q_W-2:0], fits};
      sh       <= sh >> 1;
      cnt      <= cnt - atip_pkg::CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: src/atip_dp.sv
// ----------------------------------------------------------------------------
// atip_dp
// Datapath: altitude and segment registers, table reads, multiply, divider,
// per-field result registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module atip_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire atip_pkg::cmd_t                    cmd,
  output atip_pkg::stat_t                        stat,
  input  wire logic signed [atip_pkg::ALT_W-1:0] altitude,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic        [atip_pkg::DENS_W-1:0]     density,
  output logic        [atip_pkg::GRAV_W-1:0]     gravity,
  output logic signed [atip_pkg::TEMP_W-1:0]     temperature,
  output logic        [atip_pkg::PRES_W-1:0]     pressure,
  output logic                                   below_range,
  output logic                                   above_range
);

  logic signed [atip_pkg::ALT_W-1:0]  alt;
  logic        [atip_pkg::IDX_W-1:0]  seg;
  logic        [atip_pkg::IDX_W-1:0]  seg_up;
  logic signed [atip_pkg::ALT_W-1:0]  x0;
  logic signed [atip_pkg::ALT_W-1:0]  x1;
  logic                               below;
  logic                               above;
  logic signed [atip_pkg::VAL_W-1:0]  lo;
  logic signed [atip_pkg::VAL_W-1:0]  hi;
  logic signed [atip_pkg::VAL_W-1:0]  diff;
  logic signed [atip_pkg::VAL_W-1:0]  diff_abs;
  logic signed [atip_pkg::ALT_W:0]    off_full;
  logic        [atip_pkg::OFF_W-1:0]  off;
  logic signed [atip_pkg::ALT_W:0]    dx_full;
  logic        [atip_pkg::DX_W-1:0]   dx;
  logic        [atip_pkg::PROD_W-1:0] prod_mag;
  logic                               neg;
  logic        [atip_pkg::Q_W-1:0]    quotient;
  logic signed [atip_pkg::VAL_W-1:0]  q_signed;
  logic signed [atip_pkg::VAL_W-1:0]  value;
  logic signed [atip_pkg::VAL_W-1:0]  dens_r;
  logic signed [atip_pkg::VAL_W-1:0]  grav_r;
  logic signed [atip_pkg::VAL_W-1:0]  temp_r;
  logic signed [atip_pkg::VAL_W-1:0]  pres_r;
  logic                               div_done;

  assign seg_up   = seg + atip_pkg::IDX_W'(1);
  assign x0       = atip_pkg::alt_at(seg);
  assign x1       = atip_pkg::alt_at(seg_up);
  assign below    = (alt < x0);
  assign above    = (alt > x1);
  assign lo       = atip_pkg::val_at(cmd.field, seg);
  assign hi       = atip_pkg::val_at(cmd.field, seg_up);
  assign diff     = hi - lo;
  assign diff_abs = diff[atip_pkg::VAL_W-1] ? -diff : diff;
  assign off_full = (atip_pkg::ALT_W+1)'(alt) - (atip_pkg::ALT_W+1)'(x0);
  assign off      = off_full[atip_pkg::OFF_W-1:0];
  assign dx_full  = (atip_pkg::ALT_W+1)'(x1) - (atip_pkg::ALT_W+1)'(x0);
  assign dx       = dx_full[atip_pkg::DX_W-1:0];

  assign stat.search_done =
    ((atip_pkg::IDX_W+1)'(seg) + (atip_pkg::IDX_W+1)'(2) >= (atip_pkg::IDX_W+1)'(atip_pkg::NPTS))
    || (alt <= x1);
  assign stat.div_done = div_done;
  assign stat.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      alt <= altitude;
      seg <= '0;
    end else if (cmd.seg_inc) begin
      seg <= seg_up;
    end
    if (cmd.mul) begin
      prod_mag <= diff_abs[atip_pkg::MAG_W-1:0] * off;
      neg      <= diff[atip_pkg::VAL_W-1];
    end
  end

  atip_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_mag),
    .divisor  (dx),
    .quotient (quotient),
    .done     (div_done)
  );

  assign q_signed = neg ? -atip_pkg::VAL_W'(quotient) : atip_pkg::VAL_W'(quotient);

  always_comb begin
    if (below) begin
      value = lo;
    end else if (above) begin
      value = hi;
    end else begin
      value = lo + q_signed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.field)
        atip_pkg::FLD_DENS: dens_r <= value;
        atip_pkg::FLD_GRAV: grav_r <= value;
        atip_pkg::FLD_TEMP: temp_r <= value;
        atip_pkg::FLD_PRES: pres_r <= value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      density     <= dens_r[atip_pkg::DENS_W-1:0];
      gravity     <= grav_r[atip_pkg::GRAV_W-1:0];
      temperature <= temp_r[atip_pkg::TEMP_W-1:0];
      pressure    <= pres_r[atip_pkg::PRES_W-1:0];
      below_range <= below;
      above_range <= above;
    end
  end

endmodule

`default_nettype wire

// File: src/atmosphere_table_interpolator_core.sv
// ----------------------------------------------------------------------------
// atmosphere_table_interpolator_core
// Standard-atmosphere lookup: one altitude in, density, gravity, temperature
// and pressure out by linear interpolation over a fixed breakpoint table.
// Sequence: load the altitude, walk the segments (segment index 0 to 19),
// then per field multiply, start and run the divider, and load the output.
// An altitude is taken only while the sequencer is idle; the next is taken
// while the result waits in the output register.
// Reset: rst clears the sequencer, divider and output valid; no table state.
// ----------------------------------------------------------------------------
`default_nettype none

module atmosphere_table_interpolator_core (
  input  wire logic   clk,
  input  wire logic   rst,
  atip_alt_if.sink    alt_ch,
  atip_atm_if.source  atm_ch
);

  atip_pkg::cmd_t  cmd;
  atip_pkg::stat_t stat;

  atip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (alt_ch.valid),
    .in_ready (alt_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  atip_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .altitude    (alt_ch.altitude),
    .out_valid   (atm_ch.valid),
    .out_ready   (atm_ch.ready),
    .density     (atm_ch.density),
    .gravity     (atm_ch.gravity),
    .temperature (atm_ch.temperature),
    .pressure    (atm_ch.pressure),
    .below_range (atm_ch.below_range),
    .above_range (atm_ch.above_range)
  );

endmodule

`default_nettype wire
